>>> hdl/gnl_pkg.sv
`timescale 1ns / 1ps

package gnl_pkg;

  localparam int TableSize = 256;
  localparam int IdxBits   = 8;
  localparam int FracBits  = 16;
  localparam int GradW     = 15;
  localparam int EaseW     = FracBits + 1;
  localparam int ValW      = 20;
  localparam int NoiseW    = 16;

  typedef enum logic [2:0] {
    OP_NOISE1     = 3'd0,
    OP_NOISE2     = 3'd1,
    OP_NOISE3     = 3'd2,
    OP_LOAD_PERM  = 3'd3,
    OP_LOAD_GRAD1 = 3'd4,
    OP_LOAD_GRAD2 = 3'd5,
    OP_LOAD_GRAD3 = 3'd6
  } op_t;

  typedef logic signed [ValW-1:0]  val_t;
  typedef logic [EaseW-1:0]        ease_t;
  typedef logic signed [GradW-1:0] grad_t;
  typedef logic [IdxBits-1:0]      idx_t;

endpackage

>>> hdl/gnl_blend.sv
`timescale 1ns / 1ps

// Linear interpolation a + floor((b - a) * s / 2^16) over two register stages.
module gnl_blend import gnl_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  ease_t s,
  input  val_t  a,
  input  val_t  b,
  output val_t  y
);

  localparam int ProdW = ValW + 1 + EaseW + 1;

  logic signed [ValW:0]    diff;
  logic signed [ProdW-1:0] prod;
  val_t                    a_q;

  assign diff = (ValW + 1)'(b) - (ValW + 1)'(a);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= ProdW'(diff) * ProdW'($signed({1'b0, s}));
      a_q  <= a;
      y    <= a_q + ValW'(prod >>> FracBits);
    end
  end

endmodule

>>> hdl/gradient_noise_lattice_core.sv
`timescale 1ns / 1ps

// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// Load items pass down the first stages and write each table copy at the stage that reads it.
// Reset clears the valid bits only; the tables are undefined until loaded.
module gradient_noise_lattice_core import gnl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [7:0]  lattice_x,
  input  logic [7:0]  lattice_y,
  input  logic [7:0]  lattice_z,
  input  logic [15:0] frac_x,
  input  logic [15:0] frac_y,
  input  logic [15:0] frac_z,
  input  logic [7:0]  table_index,
  input  logic [7:0]  perm_value,
  input  logic signed [14:0] grad_x,
  input  logic signed [14:0] grad_y,
  input  logic signed [14:0] grad_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] noise_value
);

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 0: input register.
  logic v0;
  op_t op0;
  idx_t lx0, ly0, lz0, idx0, pv0;
  logic [FracBits-1:0] fx0, fy0, fz0;
  grad_t gx0, gy0, gz0;

  // Stages 1 to 6.
  logic v1, v2, v3, v4, v5, v6;
  op_t op1, op2, op3, op4, op5, op6;
  idx_t lx1, ly1, lx2;
  idx_t idx1, idx2, idx3, pv1, pv2;
  grad_t gx1, gy1, gz1, gx2, gy2, gz2, gx3, gy3, gz3;
  logic [FracBits-1:0] f1 [3];
  logic [FracBits-1:0] f2 [3];
  logic [FracBits-1:0] f3 [3];
  logic [FracBits-1:0] f4 [3];
  logic [FracBits-1:0] t2_1 [3];
  ease_t s2 [3];
  ease_t s3 [3];
  ease_t s4 [3];
  ease_t s5 [3];
  ease_t s6 [3];
  idx_t pz1 [2];
  idx_t py2 [4];
  idx_t h3 [8];
  grad_t gs4 [2];
  logic [2*GradW-1:0] gp4 [4];
  logic [3*GradW-1:0] gv4 [8];
  logic signed [31:0] p5 [8][3];
  val_t c6 [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
    end
  end

  logic [31:0] sq [3];
  logic [EaseW:0] kf [3];
  logic [2*FracBits+1:0] sp [3];

  function automatic logic [FracBits-1:0] f0sel(input int d);
    logic [FracBits-1:0] r;
    case (d)
      0:       r = fx0;
      1:       r = fy0;
      default: r = fz0;
    endcase
    return r;
  endfunction

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      sq[d] = 32'(f0sel(d)) * 32'(f0sel(d));
      kf[d] = (EaseW + 1)'(3 << FracBits) - (EaseW + 1)'({f1[d], 1'b0});
      sp[d] = (2*FracBits + 2)'(t2_1[d]) * (2*FracBits + 2)'(kf[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op0 <= op_t'(opcode);
      lx0 <= lattice_x; ly0 <= lattice_y; lz0 <= lattice_z;
      fx0 <= frac_x; fy0 <= frac_y; fz0 <= frac_z;
      idx0 <= table_index; pv0 <= perm_value;
      gx0 <= grad_x; gy0 <= grad_y; gz0 <= grad_z;

      op1 <= op0; lx1 <= lx0; ly1 <= ly0;
      idx1 <= idx0; pv1 <= pv0; gx1 <= gx0; gy1 <= gy0; gz1 <= gz0;
      f1 <= '{fx0, fy0, fz0};
      for (int d = 0; d < 3; d++) t2_1[d] <= sq[d][31:16];

      op2 <= op1; lx2 <= lx1;
      idx2 <= idx1; pv2 <= pv1; gx2 <= gx1; gy2 <= gy1; gz2 <= gz1;
      f2 <= f1;
      for (int d = 0; d < 3; d++) s2[d] <= sp[d][FracBits +: EaseW];

      op3 <= op2; idx3 <= idx2; gx3 <= gx2; gy3 <= gy2; gz3 <= gz2;
      f3 <= f2; s3 <= s2;

      op4 <= op3; f4 <= f3; s4 <= s3;
      op5 <= op4; s5 <= s4;
      op6 <= op5; s6 <= s5;
    end
  end

  // Hash level one: permutation of z.
  idx_t perm_l1 [TableSize];
  idx_t lz0_1;
  assign lz0_1 = lz0 + idx_t'(1);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (v0 && op0 == OP_LOAD_PERM) perm_l1[idx0] <= pv0;
      pz1[0] <= perm_l1[lz0];
      pz1[1] <= perm_l1[lz0_1];
    end
  end

  // Hash level two: permutation of y plus the z hash for 3D noise, one copy per z corner.
  for (genvar k = 0; k < 2; k++) begin : g_l2
    idx_t mem [TableSize];
    idx_t base, a0, a1;
    assign base = (op1 == OP_NOISE3) ? pz1[k] : '0;
    assign a0   = ly1 + base;
    assign a1   = ly1 + idx_t'(1) + base;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (v1 && op1 == OP_LOAD_PERM) mem[idx1] <= pv1;
        py2[2*k]     <= mem[a0];
        py2[2*k + 1] <= mem[a1];
      end
    end
  end

  // Hash level three: permutation of x plus the inner hash except for 1D noise, one copy per y-z corner.
  for (genvar m = 0; m < 4; m++) begin : g_l3
    idx_t mem [TableSize];
    idx_t base, a0, a1;
    assign base = (op2 == OP_NOISE1) ? '0 : py2[m];
    assign a0   = lx2 + base;
    assign a1   = lx2 + idx_t'(1) + base;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (v2 && op2 == OP_LOAD_PERM) mem[idx2] <= pv2;
        h3[2*m]     <= mem[a0];
        h3[2*m + 1] <= mem[a1];
      end
    end
  end

  // Gradient tables.
  grad_t scal_mem [TableSize];
  always_ff @(posedge clk) begin
    if (adv) begin
      if (v3 && op3 == OP_LOAD_GRAD1) scal_mem[idx3] <= gx3;
      gs4[0] <= scal_mem[h3[0]];
      gs4[1] <= scal_mem[h3[1]];
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_plan
    logic [2*GradW-1:0] mem [TableSize];
    always_ff @(posedge clk) begin
      if (adv) begin
        if (v3 && op3 == OP_LOAD_GRAD2) mem[idx3] <= {gy3, gx3};
        gp4[2*c]     <= mem[h3[2*c]];
        gp4[2*c + 1] <= mem[h3[2*c + 1]];
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_spat
    logic [3*GradW-1:0] mem [TableSize];
    always_ff @(posedge clk) begin
      if (adv) begin
        if (v3 && op3 == OP_LOAD_GRAD3) mem[idx3] <= {gz3, gy3, gx3};
        gv4[2*c]     <= mem[h3[2*c]];
        gv4[2*c + 1] <= mem[h3[2*c + 1]];
      end
    end
  end

  // Corner products.
  grad_t gsel [8][3];
  logic signed [FracBits:0] rsel [8][3];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      case (op4)
        OP_NOISE1: begin
          gsel[i][0] = gs4[i % 2];
          gsel[i][1] = '0;
          gsel[i][2] = '0;
        end
        OP_NOISE2: begin
          gsel[i][0] = gp4[i % 4][GradW-1:0];
          gsel[i][1] = gp4[i % 4][2*GradW-1:GradW];
          gsel[i][2] = '0;
        end
        default: begin
          gsel[i][0] = gv4[i][GradW-1:0];
          gsel[i][1] = gv4[i][2*GradW-1:GradW];
          gsel[i][2] = gv4[i][3*GradW-1:2*GradW];
        end
      endcase
      for (int d = 0; d < 3; d++) begin
        rsel[i][d] = $signed({((i >> d) & 1) == 1, f4[d]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) begin
        for (int d = 0; d < 3; d++) begin
          p5[i][d] <= 32'(gsel[i][d]) * 32'(rsel[i][d]);
        end
      end
    end
  end

  logic signed [33:0] csum [8];
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      csum[i] = 34'(p5[i][0]) + 34'(p5[i][1]) + 34'(p5[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) c6[i] <= ValW'(csum[i] >>> FracBits);
    end
  end

  // Blend tree: x, then y, then z.
  logic v_d [7:12];
  op_t op_d [7:12];
  ease_t sy_d [7:8];
  ease_t sz_d [7:10];
  val_t bx [4];
  val_t by [2];
  val_t bz;
  val_t bx0_d [9:12];
  val_t by0_d [11:12];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 7; k <= 12; k++) v_d[k] <= 1'b0;
    end else if (adv) begin
      v_d[7] <= v6;
      for (int k = 8; k <= 12; k++) v_d[k] <= v_d[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_d[7] <= op6;
      for (int k = 8; k <= 12; k++) op_d[k] <= op_d[k-1];
      sy_d[7] <= s6[1];
      sy_d[8] <= sy_d[7];
      sz_d[7] <= s6[2];
      for (int k = 8; k <= 10; k++) begin
        sz_d[k] <= sz_d[k-1];
      end
      bx0_d[9] <= bx[0];
      for (int k = 10; k <= 12; k++) bx0_d[k] <= bx0_d[k-1];
      by0_d[11] <= by[0];
      by0_d[12] <= by0_d[11];
    end
  end

  for (genvar m = 0; m < 4; m++) begin : g_bx
    gnl_blend u_blend (
      .clk (clk), .en (adv), .s (s6[0]),
      .a (c6[2*m]), .b (c6[2*m + 1]), .y (bx[m])
    );
  end

  for (genvar k = 0; k < 2; k++) begin : g_by
    gnl_blend u_blend (
      .clk (clk), .en (adv), .s (sy_d[8]),
      .a (bx[2*k]), .b (bx[2*k + 1]), .y (by[k])
    );
  end

  gnl_blend u_bz (
    .clk (clk), .en (adv), .s (sz_d[10]),
    .a (by[0]), .b (by[1]), .y (bz)
  );

  // Output stage with saturation.
  val_t res;
  logic is_noise;

  always_comb begin
    case (op_d[12])
      OP_NOISE1: res = bx0_d[12];
      OP_NOISE2: res = by0_d[12];
      default:   res = bz;
    endcase
    is_noise = (op_d[12] == OP_NOISE1) || (op_d[12] == OP_NOISE2) ||
               (op_d[12] == OP_NOISE3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v_d[12] && is_noise;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (res > val_t'(32767)) begin
        noise_value <= NoiseW'(32767);
      end else if (res < -val_t'(32768)) begin
        noise_value <= NoiseW'(-32768);
      end else begin
        noise_value <= NoiseW'(res);
      end
    end
  end

endmodule

>>> sim/tb_gradient_noise_lattice_core.sv
`timescale 1ns / 1ps

module tb_gradient_noise_lattice_core;
  import gnl_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;

  typedef struct {
    logic [2:0]         opcode;
    logic [7:0]         lx, ly, lz;
    logic [15:0]        fx, fy, fz;
    logic [7:0]         index;
    logic [7:0]         pval;
    logic signed [14:0] gx, gy, gz;
  } lattice_item_t;

  class noise_scoreboard;
    logic [7:0]    perm[TableSize];
    int            grad1[TableSize];
    int            grad2[TableSize][2];
    int            grad3[TableSize][3];
    shortint       pending_noise[$];
    int            fails;
    int            checked;
    int            loads;

    function logic [7:0] hash1(logic [7:0] x);
      return perm[x];
    endfunction

    function logic [7:0] hash2(logic [7:0] x, logic [7:0] y);
      return hash1(x + hash1(y));
    endfunction

    function logic [7:0] hash3(logic [7:0] x, logic [7:0] y, logic [7:0] z);
      return hash1(x + hash1(y + hash1(z)));
    endfunction

    function longint ease(longint t);
      longint t2;
      t2 = (t * t) >>> FracBits;
      return (t2 * ((longint'(3) << FracBits) - 2 * t)) >>> FracBits;
    endfunction

    function longint blend(longint s, longint a, longint b);
      return a + (((b - a) * s) >>> FracBits);
    endfunction

    function longint dot1(logic [7:0] x, longint rx);
      return (longint'(grad1[hash1(x)]) * rx) >>> FracBits;
    endfunction

    function longint dot2(logic [7:0] x, logic [7:0] y, longint rx, longint ry);
      logic [7:0] h;
      h = hash2(x, y);
      return (grad2[h][0] * rx + grad2[h][1] * ry) >>> FracBits;
    endfunction

    function longint dot3(logic [7:0] x, logic [7:0] y, logic [7:0] z,
                          longint rx, longint ry, longint rz);
      logic [7:0] h;
      h = hash3(x, y, z);
      return (grad3[h][0] * rx + grad3[h][1] * ry + grad3[h][2] * rz) >>> FracBits;
    endfunction

    function void note_input(lattice_item_t it);
      longint one, ax, ay, az, bx, by, bz, sx, sy, sz, a, b, c, d, res;
      logic [7:0] x1, y1, z1;
      one = longint'(1) << FracBits;
      ax = it.fx; ay = it.fy; az = it.fz;
      bx = ax - one; by = ay - one; bz = az - one;
      x1 = it.lx + 8'd1; y1 = it.ly + 8'd1; z1 = it.lz + 8'd1;
      sx = ease(ax); sy = ease(ay); sz = ease(az);
      case (it.opcode)
        OP_NOISE1: res = blend(sx, dot1(it.lx, ax), dot1(x1, bx));
        OP_NOISE2: begin
          a = blend(sx, dot2(it.lx, it.ly, ax, ay), dot2(x1, it.ly, bx, ay));
          b = blend(sx, dot2(it.lx, y1, ax, by), dot2(x1, y1, bx, by));
          res = blend(sy, a, b);
        end
        OP_NOISE3: begin
          a = blend(sx, dot3(it.lx, it.ly, it.lz, ax, ay, az),
                    dot3(x1, it.ly, it.lz, bx, ay, az));
          b = blend(sx, dot3(it.lx, y1, it.lz, ax, by, az),
                    dot3(x1, y1, it.lz, bx, by, az));
          c = blend(sy, a, b);
          a = blend(sx, dot3(it.lx, it.ly, z1, ax, ay, bz),
                    dot3(x1, it.ly, z1, bx, ay, bz));
          b = blend(sx, dot3(it.lx, y1, z1, ax, by, bz),
                    dot3(x1, y1, z1, bx, by, bz));
          d = blend(sy, a, b);
          res = blend(sz, c, d);
        end
        OP_LOAD_PERM: begin
          perm[it.index] = it.pval;
          loads++;
          return;
        end
        OP_LOAD_GRAD1: begin
          grad1[it.index] = it.gx;
          loads++;
          return;
        end
        OP_LOAD_GRAD2: begin
          grad2[it.index][0] = it.gx;
          grad2[it.index][1] = it.gy;
          loads++;
          return;
        end
        OP_LOAD_GRAD3: begin
          grad3[it.index][0] = it.gx;
          grad3[it.index][1] = it.gy;
          grad3[it.index][2] = it.gz;
          loads++;
          return;
        end
        default: return;
      endcase
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      pending_noise.push_back(shortint'(res));
    endfunction

    function void check_result(logic signed [15:0] actual);
      shortint expected;
      if (pending_noise.size() == 0) begin
        $display("%0t: unexpected noise result %0d", $time, actual);
        fails++;
        return;
      end
      expected = pending_noise.pop_front();
      checked++;
      if (actual !== expected) begin
        $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                 $time, expected, actual);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] opcode = '0;
  logic [7:0] lattice_x = '0, lattice_y = '0, lattice_z = '0;
  logic [15:0] frac_x = '0, frac_y = '0, frac_z = '0;
  logic [7:0] table_index = '0, perm_value = '0;
  logic signed [14:0] grad_x = '0, grad_y = '0, grad_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] noise_value;

  noise_scoreboard sb = new();
  int  cycles = 0;
  bit  steady = 1'b0;
  bit  long_hold_req = 1'b0;

  always #2 clk = ~clk;

  gradient_noise_lattice_core i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .lattice_x(lattice_x), .lattice_y(lattice_y),
    .lattice_z(lattice_z), .frac_x(frac_x), .frac_y(frac_y), .frac_z(frac_z),
    .table_index(table_index), .perm_value(perm_value),
    .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
    .out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
  );

  function automatic int idle_length();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[gradient_noise_lattice_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(noise_value);
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_stall = 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 300;
        out_stall = 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
        if ($urandom_range(0, 4) == 0) hold = idle_length();
      end
    end
  end

  task automatic send_item(lattice_item_t it);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    opcode = it.opcode;
    lattice_x = it.lx; lattice_y = it.ly; lattice_z = it.lz;
    frac_x = it.fx; frac_y = it.fy; frac_z = it.fz;
    table_index = it.index; perm_value = it.pval;
    grad_x = it.gx; grad_y = it.gy; grad_z = it.gz;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  function automatic lattice_item_t random_item(logic [2:0] op);
    lattice_item_t it;
    it.opcode = op;
    it.lx = 8'($urandom); it.ly = 8'($urandom); it.lz = 8'($urandom);
    it.fx = 16'($urandom); it.fy = 16'($urandom); it.fz = 16'($urandom);
    it.index = 8'($urandom); it.pval = 8'($urandom);
    it.gx = 15'($urandom); it.gy = 15'($urandom); it.gz = 15'($urandom);
    return it;
  endfunction

  initial begin
    lattice_item_t it;
    int r, counted;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < TableSize; i++) begin
      for (int op = OP_LOAD_PERM; op <= OP_LOAD_GRAD3; op++) begin
        it = random_item(op[2:0]);
        it.index = 8'(i);
        if (i == 0) begin
          it.gx = -15'sd16384; it.gy = -15'sd16384; it.gz = -15'sd16384;
        end else if (i == 1) begin
          it.gx = 15'sd16383; it.gy = 15'sd16383; it.gz = 15'sd16383;
        end
        send_item(it);
      end
    end

    for (int op = OP_NOISE1; op <= OP_NOISE3; op++) begin
      for (int k = 0; k < 6; k++) begin
        it = random_item(op[2:0]);
        case (k)
          0: begin it.fx = '0; it.fy = '0; it.fz = '0; end
          1: begin it.fx = 16'hFFFF; it.fy = 16'hFFFF; it.fz = 16'hFFFF; end
          2: begin it.fx = 16'h8000; it.fy = 16'h8000; it.fz = 16'h8000; end
          3: begin it.lx = 8'hFF; it.ly = 8'hFF; it.lz = 8'hFF; end
          4: begin it.lx = '0; it.ly = '0; it.lz = '0; end
          default: begin it.lx = 8'hFF; it.fx = 16'hFFFF; it.fy = '0; end
        endcase
        send_item(it);
      end
    end
    send_item(random_item(OP_UNUSED));

    long_hold_req = 1'b1;
    counted = 0;
    while (counted < 400) begin
      steady = ((counted / 150) % 4) == 2;
      r = $urandom_range(0, 99);
      if (r < 80) it = random_item(3'($urandom_range(OP_NOISE1, OP_NOISE3)));
      else if (r < 95) it = random_item(3'($urandom_range(OP_LOAD_PERM, OP_LOAD_GRAD3)));
      else it = random_item(OP_UNUSED);
      send_item(it);
      counted++;
    end
    steady = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;

    while (sb.pending_noise.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Checked %0d noise samples in 1, 2 and 3 dimensions after %0d table loads,",
             sb.checked, sb.loads);
    $display("with random idling on both sides and one long output hold-off.");
    if (sb.fails == 0 && sb.pending_noise.size() == 0) begin
      $display("[gradient_noise_lattice_core] OK");
    end else begin
      $display("[gradient_noise_lattice_core] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/gnl_pkg.sv
hdl/gnl_blend.sv
hdl/gradient_noise_lattice_core.sv
sim/tb_gradient_noise_lattice_core.sv
